>>> rtl/core/iplpm_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 LPM table - shared package
// Command and status codes, the probe word that walks the cell row, the
// commit word sent to one cell and the prefix mask helper.
// ----------------------------------------------------------------------------
package iplpm_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_DEL   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    localparam logic signed [6:0] NO_MATCH = -7'sd1;

    // Word carried from cell to cell, one hop per cycle
    typedef struct packed {
        logic              active;
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;      // raw address, used by queries
        logic [ADDR_W-1:0] base;      // address masked to len
        logic [LEN_W-1:0]  len;       // saturated length
        logic              hit;       // exact prefix seen so far
        logic              free_seen; // an empty slot seen so far
        logic              best_ok;   // some entry matched the query
        logic [LEN_W-1:0]  best_len;
    } t_probe;

    // Write into one cell once the probe has left the row
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
    } t_commit;

    // Top len bits set; len is at most ADDR_W
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        len_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

>>> rtl/core/iplpm_if.sv
// ----------------------------------------------------------------------------
// IPv4 LPM table - channel interfaces
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iplpm_cmd_if;
    logic                                valid;
    logic                                ready;
    iplpm_pkg::t_cmd                     cmd;
    logic [31:0]                         address;
    logic [5:0]                          prefix_len;

    modport source (output valid, output cmd, output address, output prefix_len,
                    input ready);
    modport sink   (input valid, input cmd, input address, input prefix_len,
                    output ready);
endinterface

interface iplpm_res_if;
    logic                                valid;
    logic                                ready;
    iplpm_pkg::t_status                  status;
    logic signed [6:0]                   match_len;

    modport source (output valid, output status, output match_len, input ready);
    modport sink   (input valid, input status, input match_len, output ready);
endinterface

>>> rtl/core/ipv4_prefix_table_lpm_unit.sv
// ----------------------------------------------------------------------------
// IPv4 prefix table with longest-prefix match
// Add / delete / query on a row of prefix cells, one result word per command.
// ----------------------------------------------------------------------------
// The table holds up to TABLE_ENTRIES prefixes (base + length 0..32), one per
// cell in a row. A command word is taken on i_cmd only while the unit is
// idle; it then walks the row one cell per cycle, each cell folding in its own
// compare (exact hit, first empty slot, longest query match). When the word
// drops off the end, the outcome is decided, at most one cell is written (add
// into the lowest empty slot, or delete of the exact hit) and the result word
// is loaded into the output register. The unit takes a new command only once
// the previous one has walked the whole row and its result has been loaded.
// The output register lets the next command be taken while a result still
// waits on o_res; a command only stalls at the end of its walk if the
// previous result has not been taken. Slot valid bits are cleared by reset
// at once, so there is no clearing pass. Lengths above 32 are treated as 32;
// a query returns status done and the longest matching length, or -1; every
// other command returns -1 in match_len. Command code 3 does nothing and
// returns done.
// ----------------------------------------------------------------------------
module ipv4_prefix_table_lpm_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iplpm_cmd_if.sink   i_cmd,
    iplpm_res_if.source o_res
);
    import iplpm_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    t_state            r_state;

    // tail of the row, latched when the probe word leaves the last cell
    t_probe            r_tail;
    logic [IDX_W-1:0]  r_tail_hit_idx;
    logic [IDX_W-1:0]  r_tail_free_idx;

    // output register
    logic              r_out_valid;
    t_status           r_status;
    logic signed [6:0] r_match;

    // row wiring: element k feeds cell k
    t_probe            w_probe    [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]  w_hit_idx  [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]  w_free_idx [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_wr_en;

    logic              w_accept;
    logic              w_out_free;
    logic              w_fin_go;
    logic [LEN_W-1:0]  w_len_sat;

    t_status           w_status;
    logic signed [6:0] w_match;
    t_commit           w_commit;
    logic              w_do_wr;
    logic [IDX_W-1:0]  w_wr_idx;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_fin_go    = (r_state == S_FIN) && w_out_free;

    // saturate the length and mask the base on the way in
    assign w_len_sat = (i_cmd.prefix_len > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W)
                                                           : i_cmd.prefix_len;

    always_comb begin
        w_probe[0]           = '0;
        w_probe[0].active    = w_accept;
        w_probe[0].cmd       = i_cmd.cmd;
        w_probe[0].addr      = i_cmd.address;
        w_probe[0].len       = w_len_sat;
        w_probe[0].base      = i_cmd.address & len_mask(w_len_sat);
    end
    assign w_hit_idx[0]  = '0;
    assign w_free_idx[0] = '0;

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        assign w_wr_en[k] = w_do_wr && (w_wr_idx == IDX_W'(k));

        iplpm_cell #(
            .IDX_W   (IDX_W),
            .CELL_ID (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_probe    (w_probe[k]),
            .i_hit_idx  (w_hit_idx[k]),
            .i_free_idx (w_free_idx[k]),
            .o_probe    (w_probe[k+1]),
            .o_hit_idx  (w_hit_idx[k+1]),
            .o_free_idx (w_free_idx[k+1]),
            .i_wr_en    (w_wr_en[k]),
            .i_commit   (w_commit)
        );
    end

    // decide the outcome from the tail word
    always_comb begin
        w_status      = ST_DONE;
        w_match       = NO_MATCH;
        w_commit.set  = 1'b0;
        w_commit.clr  = 1'b0;
        w_commit.base = r_tail.base;
        w_commit.len  = r_tail.len;
        w_wr_idx      = r_tail_free_idx;
        case (r_tail.cmd)
            CMD_ADD: begin
                if (r_tail.hit) begin
                    w_status = ST_PRESENT;
                end else if (!r_tail.free_seen) begin
                    w_status = ST_FULL;
                end else begin
                    w_commit.set = 1'b1;
                end
            end
            CMD_DEL: begin
                w_wr_idx = r_tail_hit_idx;
                if (r_tail.hit) begin
                    w_commit.clr = 1'b1;
                end else begin
                    w_status = ST_ABSENT;
                end
            end
            CMD_QUERY: begin
                if (r_tail.best_ok) begin
                    w_match = $signed({1'b0, r_tail.best_len});
                end
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
        w_do_wr = w_fin_go && (w_commit.set || w_commit.clr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a waiting word leaves unless a new one replaces it this cycle
            if (o_res.ready && !w_fin_go) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_probe[TABLE_ENTRIES].active) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_status    <= w_status;
                        r_match     <= w_match;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && w_probe[TABLE_ENTRIES].active) begin
            r_tail          <= w_probe[TABLE_ENTRIES];
            r_tail_hit_idx  <= w_hit_idx[TABLE_ENTRIES];
            r_tail_free_idx <= w_free_idx[TABLE_ENTRIES];
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_status;
    assign o_res.match_len = r_match;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_wr_en))
        else $error("more than one cell written in a cycle");

    a_tail_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[TABLE_ENTRIES].active |-> (r_state == S_RUN))
        else $error("probe word left the row outside a walk");

    a_match_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_match != NO_MATCH)) |-> (r_status == ST_DONE))
        else $error("match length reported with a non-done status");

    a_accept_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RUN) && w_probe[1].active)
        else $error("accepted command did not enter the cell row");

endmodule

>>> rtl/core/iplpm_cell.sv
// ----------------------------------------------------------------------------
// IPv4 LPM table - table cell
// Holds one prefix slot. Compares the passing probe word against its slot,
// updates the running hit / free / best fields and hands the word on.
// ----------------------------------------------------------------------------
module iplpm_cell #(
    parameter int IDX_W   = 6,
    parameter int CELL_ID = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iplpm_pkg::t_probe    i_probe,
    input  logic [IDX_W-1:0]     i_hit_idx,
    input  logic [IDX_W-1:0]     i_free_idx,
    output iplpm_pkg::t_probe    o_probe,
    output logic [IDX_W-1:0]     o_hit_idx,
    output logic [IDX_W-1:0]     o_free_idx,
    input  logic                 i_wr_en,
    input  iplpm_pkg::t_commit   i_commit
);
    import iplpm_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic              r_valid;
    logic              r_active;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;

    t_probe            r_probe, n_probe;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;

    logic              w_exact;
    logic              w_qmatch;

    assign w_exact  = r_valid && (r_len == i_probe.len) && (r_addr == i_probe.base);
    assign w_qmatch = r_valid && ((i_probe.addr & len_mask(r_len)) == r_addr);

    always_comb begin
        n_probe    = i_probe;
        n_hit_idx  = i_hit_idx;
        n_free_idx = i_free_idx;
        if (w_exact) begin
            n_probe.hit = 1'b1;
            n_hit_idx   = MY_IDX;
        end
        if (!r_valid && !i_probe.free_seen) begin
            n_probe.free_seen = 1'b1;
            n_free_idx        = MY_IDX;
        end
        if (w_qmatch && (!i_probe.best_ok || (r_len > i_probe.best_len))) begin
            n_probe.best_ok  = 1'b1;
            n_probe.best_len = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_active <= n_probe.active;
            if (i_wr_en && i_commit.set) begin
                r_valid <= 1'b1;
            end else if (i_wr_en && i_commit.clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload, no reset; the active flag comes from r_active
    always_ff @(posedge i_clk) begin
        r_probe    <= n_probe;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        if (i_wr_en && i_commit.set) begin
            r_addr <= i_commit.base;
            r_len  <= i_commit.len;
        end
    end

    always_comb begin
        o_probe        = r_probe;
        o_probe.active = r_active;
    end

    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule

>>> tb/iplpm_lpm_checker.sv
// ----------------------------------------------------------------------------
// IPv4 LPM table - result checker
// Watches the command and result channels, keeps its own copy of the prefix
// table, predicts one result word per accepted command and compares in order.
// ----------------------------------------------------------------------------
module iplpm_lpm_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    iplpm_cmd_if i_cmd_mon,
    iplpm_res_if i_res_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_seen,
    output int   o_hit_seen
);
    import iplpm_pkg::*;

    typedef struct packed {
        t_status           status;
        logic signed [6:0] match_len;
    } t_lpm_word;

    // Shadow table
    logic              slot_used [TABLE_ENTRIES];
    logic [ADDR_W-1:0] slot_base [TABLE_ENTRIES];
    logic [LEN_W-1:0]  slot_len  [TABLE_ENTRIES];

    t_lpm_word result_q [$];
    int        fails;
    int        checked;
    int        fulls;
    int        hits;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        if (len == '0)
            return '0;
        return {ADDR_W{1'b1}} << (ADDR_W - int'(len));
    endfunction

    // Applies one command to the shadow table and returns its result word
    function automatic t_lpm_word lpm_apply(input t_cmd op, input logic [ADDR_W-1:0] addr,
                                            input logic [LEN_W-1:0] len_raw);
        t_lpm_word         res;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] base;
        int                hit_slot;
        int                free_slot;
        int                best;
        res.status    = ST_DONE;
        res.match_len = NO_MATCH;
        len       = (len_raw > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : len_raw;
        base      = addr & prefix_mask(len);
        hit_slot  = -1;
        free_slot = -1;
        best      = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[i]) begin
                if (hit_slot < 0 && slot_len[i] == len && slot_base[i] == base)
                    hit_slot = i;
                if ((addr & prefix_mask(slot_len[i])) == slot_base[i] &&
                    int'(slot_len[i]) > best)
                    best = int'(slot_len[i]);
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        case (op)
            CMD_ADD: begin
                if (hit_slot >= 0) begin
                    res.status = ST_PRESENT;
                end else if (free_slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    slot_used[free_slot] = 1'b1;
                    slot_base[free_slot] = base;
                    slot_len[free_slot]  = len;
                end
            end
            CMD_DEL: begin
                if (hit_slot < 0)
                    res.status = ST_ABSENT;
                else
                    slot_used[hit_slot] = 1'b0;
            end
            CMD_QUERY: begin
                if (best >= 0)
                    res.match_len = 7'(best);
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_lpm_word want;
        t_lpm_word got;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                slot_used[i] = 1'b0;
            result_q.delete();
        end else begin
            // Result side first: a word can never come back in its own cycle
            if (i_res_mon.valid && i_res_mon.ready) begin
                got.status    = i_res_mon.status;
                got.match_len = i_res_mon.match_len;
                if (result_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word: expected none, got status %0d match_len %0d",
                             $time, got.status, got.match_len);
                end else begin
                    want = result_q.pop_front();
                    checked++;
                    if (got.status !== want.status) begin
                        fails++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.match_len !== want.match_len) begin
                        fails++;
                        $display("%0t: match_len mismatch: expected %0d, got %0d",
                                 $time, want.match_len, got.match_len);
                    end
                end
            end
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                want = lpm_apply(i_cmd_mon.cmd, i_cmd_mon.address, i_cmd_mon.prefix_len);
                if (want.status == ST_FULL)
                    fulls++;
                if (want.match_len != NO_MATCH)
                    hits++;
                result_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_q.size();
        o_checked    <= checked;
        o_full_seen  <= fulls;
        o_hit_seen   <= hits;
    end

endmodule

>>> tb/tb_ipv4_prefix_table_lpm_unit.sv
// ----------------------------------------------------------------------------
// IPv4 LPM table - testbench top
// Drives add / delete / query / no-op command words with bursty timing and a
// stalling result receiver; a checker beside the unit predicts every result.
// ----------------------------------------------------------------------------
module tb_ipv4_prefix_table_lpm_unit;
    import iplpm_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int RANDOM_WORDS  = 1900;
    localparam int PHASE_WORDS   = 150;    // words per table-pressure phase
    localparam int POOL_DEPTH    = 128;    // recent prefixes kept for reuse
    // Slowest legal run is about 2000 words, each with a full walk, the longest
    // gap and the longest stall; the limit sits well above that.
    localparam int CYCLE_LIMIT   = 2_000_000;
    // Walk length plus margin, for words still in flight at the end
    localparam int DRAIN_CYCLES  = TABLE_ENTRIES + 32;

    logic i_clk;
    logic i_rst_n;

    iplpm_cmd_if cmd_if ();
    iplpm_res_if res_if ();

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int hit_seen;

    int cycle_cnt;
    int burst_left;
    int n_add;
    int n_del;
    int n_query;
    int n_nop;

    // Prefixes recently offered for add; deletes and queries aim at these
    logic [31:0] pool_addr [$];
    logic [5:0]  pool_len  [$];

    ipv4_prefix_table_lpm_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    iplpm_lpm_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_mon   (cmd_if),
        .i_res_mon   (res_if),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_seen (full_seen),
        .o_hit_seen  (hit_seen)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d words outstanding",
                     $time, cycle_cnt, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result receiver: alternating ready and stall runs. Some stalls outlast a
    // whole walk, so the unit has to hold its result and stall the next command
    // at the end of its walk.
    initial begin : res_sink
        int   run_left;
        logic level;
        res_if.ready <= 1'b0;
        run_left = 0;
        level    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_left == 0) begin
                level = ~level;
                if (level)
                    run_left = $urandom_range(1, 200);
                else if ($urandom_range(0, 7) == 0)
                    run_left = $urandom_range(20, 100);
                else
                    run_left = $urandom_range(1, 4);
            end
            res_if.ready <= level;
            run_left--;
        end
    end

    // One command word; returns right after the edge that accepted it.
    // Bursts end with a random gap, long ones landing anywhere in a walk.
    task automatic send_word(input t_cmd op, input logic [31:0] addr, input logic [5:0] len);
        int gap;
        cmd_if.valid      <= 1'b1;
        cmd_if.cmd        <= op;
        cmd_if.address    <= addr;
        cmd_if.prefix_len <= len;
        do
            @(posedge i_clk);
        while (!cmd_if.ready);
        case (op)
            CMD_ADD:   n_add++;
            CMD_DEL:   n_del++;
            CMD_QUERY: n_query++;
            default:   n_nop++;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(10, 90);
            else
                gap = $urandom_range(1, 6);
            // Junk payload while idle must be ignored
            cmd_if.valid      <= 1'b0;
            cmd_if.address    <= $urandom;
            cmd_if.prefix_len <= 6'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly 1..31, with /0, /32 and over-long lengths mixed in
    function automatic logic [5:0] pick_len();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 6'd0;
        if (k == 1)
            return 6'd32;
        if (k == 2)
            return 6'($urandom_range(33, 63));
        return 6'($urandom_range(1, 31));
    endfunction

    // Randomise the bits below the prefix; the prefix itself is kept
    function automatic logic [31:0] scramble_low(input logic [31:0] a, input logic [5:0] l);
        if (l >= 6'd32)
            return a;
        return a ^ ($urandom >> l);
    endfunction

    task automatic send_random_word(input int add_pct, input int del_pct);
        int          pick;
        int          idx;
        logic [31:0] addr;
        logic [5:0]  len;
        pick = $urandom_range(0, 99);
        idx  = (pool_addr.size() > 0) ? $urandom_range(0, pool_addr.size() - 1) : -1;
        if (pick < add_pct) begin
            if (idx >= 0 && $urandom_range(0, 3) == 0) begin
                // re-add of a known prefix, usually still present
                len  = pool_len[idx];
                addr = scramble_low(pool_addr[idx], len);
            end else begin
                len = pick_len();
                // relatives of known prefixes give nested and sibling routes
                if (idx >= 0 && $urandom_range(0, 1) == 1)
                    addr = pool_addr[idx] ^ ($urandom >> $urandom_range(0, 31));
                else
                    addr = $urandom;
                pool_addr.push_back(addr);
                pool_len.push_back(len);
                if (pool_addr.size() > POOL_DEPTH) begin
                    void'(pool_addr.pop_front());
                    void'(pool_len.pop_front());
                end
            end
            send_word(CMD_ADD, addr, len);
        end else if (pick < add_pct + del_pct) begin
            if (idx >= 0 && $urandom_range(0, 3) != 0) begin
                len  = pool_len[idx];
                addr = scramble_low(pool_addr[idx], len);
            end else begin
                len  = pick_len();
                addr = $urandom;
            end
            send_word(CMD_DEL, addr, len);
        end else if (pick < 97) begin
            // Length is don't-care for a query: keep it random
            if (idx >= 0 && $urandom_range(0, 9) < 7)
                addr = scramble_low(pool_addr[idx], pool_len[idx]);
            else
                addr = $urandom;
            send_word(CMD_QUERY, addr, 6'($urandom_range(0, 63)));
        end else begin
            send_word(CMD_NOP, $urandom, 6'($urandom_range(0, 63)));
        end
    endtask

    initial begin : stimulus
        int sent;
        int phase;
        int add_pct;
        int del_pct;
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.cmd        <= CMD_NOP;
        cmd_if.address    <= '0;
        cmd_if.prefix_len <= '0;
        burst_left = $urandom_range(1, 30);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, /0 and /32 extremes, saturated lengths,
        // low bits ignored, duplicate add, absent delete, no-op code
        send_word(CMD_QUERY, 32'h0000_0000, 6'd0);    // empty: no match
        send_word(CMD_QUERY, 32'hFFFF_FFFF, 6'd63);
        send_word(CMD_ADD,   32'hFFFF_FFFF, 6'd32);
        send_word(CMD_ADD,   32'hFFFF_FFFF, 6'd63);   // saturates to /32: present
        send_word(CMD_ADD,   32'h0000_0000, 6'd0);    // default route
        send_word(CMD_QUERY, 32'h1234_5678, 6'd0);    // only /0 matches
        send_word(CMD_QUERY, 32'hFFFF_FFFF, 6'd0);    // /32 wins
        send_word(CMD_ADD,   32'h0A01_0203, 6'd8);    // stored as 10.0.0.0/8
        send_word(CMD_ADD,   32'h0AFF_0000, 6'd8);    // same prefix: present
        send_word(CMD_QUERY, 32'h0A7F_0001, 6'd0);
        send_word(CMD_DEL,   32'h0AC8_0000, 6'd8);    // low bits ignored
        send_word(CMD_DEL,   32'h0A00_0000, 6'd8);    // now absent
        send_word(CMD_QUERY, 32'h0A00_0000, 6'd0);
        send_word(CMD_NOP,   32'hFFFF_FFFF, 6'd63);
        send_word(CMD_NOP,   32'h0000_0000, 6'd0);
        send_word(CMD_DEL,   32'h0000_0000, 6'd0);
        send_word(CMD_QUERY, 32'h0A00_0000, 6'd0);    // nothing left to match
        send_word(CMD_DEL,   32'hFFFF_FFFF, 6'd40);   // saturated delete
        send_word(CMD_DEL,   32'hFFFF_FFFF, 6'd32);   // already gone
        send_word(CMD_ADD,   32'h8000_0000, 6'd1);
        send_word(CMD_ADD,   32'hC000_0000, 6'd2);
        send_word(CMD_QUERY, 32'hC000_0001, 6'd0);    // nested: /2 over /1
        send_word(CMD_QUERY, 32'h4000_0000, 6'd0);
        send_word(CMD_ADD,   32'h5555_5555, 6'd31);
        send_word(CMD_QUERY, 32'h5555_5555, 6'd0);

        // Random: phases alternate between filling past full, mixed traffic
        // and draining, so every table occupancy gets exercised
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            case (phase % 4)
                0:       begin add_pct = 85; del_pct = 5;  end
                1:       begin add_pct = 40; del_pct = 20; end
                2:       begin add_pct = 10; del_pct = 65; end
                default: begin add_pct = 50; del_pct = 25; end
            endcase
            send_random_word(add_pct, del_pct);
            sent++;
            if (sent % PHASE_WORDS == 0)
                phase++;
        end
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d adds, %0d deletes, %0d queries, %0d no-ops; %0d result words checked",
                 n_add, n_del, n_query, n_nop, checked);
        $display("Table-full refusals: %0d, queries with a match: %0d", full_seen, hit_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures, %0d results outstanding", fail_count, pending);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
